// File: rtl/brr_pkg.sv
// ----------------------------------------------------------------------------
// brr_pkg: shared types and constants of the byte range remover
// Position width, cell count, request and status codes, and the token that
// travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package brr_pkg;

   localparam int RANGE_CELLS = 64;
   localparam int POS_BITS    = 48;
   localparam int IN_BITS     = 48;
   localparam int PAD_BITS    = 32;
   localparam int CMP_BITS    = (POS_BITS > PAD_BITS + 1) ? POS_BITS : PAD_BITS + 1;

   typedef logic [POS_BITS-1:0] pos_type;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_DATA  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_STORED = 2'd0,
      ST_SHORT  = 2'd1,
      ST_ORDER  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic         vld;
      req_code_type op;
      pos_type      pos;
      pos_type      start;
      pos_type      stop;
      logic [7:0]   data;
      logic         done;
      status_type   status;
      logic         drop;
   } token_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/brr_head.sv
// ----------------------------------------------------------------------------
// brr_head: chain entry
// Holds the stream position and padding, checks and shrinks load ranges and
// issues one token per accepted transaction into the first cell.
// ----------------------------------------------------------------------------
`default_nettype none

module brr_head
   import brr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_type,
   input  wire logic [IN_BITS-1:0] range_lo,
   input  wire logic [IN_BITS-1:0] range_hi,
   input  wire logic [7:0]         data_byte,
   input  wire logic               csr_valid,
   input  wire logic [PAD_BITS-1:0] csr_data,
   output token_type               token
);

   pos_type             position_ff, position_in;
   logic [PAD_BITS-1:0] padding_ff;
   pos_type             lo, hi, pad;
   logic [CMP_BITS-1:0] diff, twice;
   req_code_type        op;

   assign op    = req_code_type'(req_type);
   assign lo    = POS_BITS'(range_lo);
   assign hi    = POS_BITS'(range_hi);
   assign pad   = POS_BITS'(padding_ff);
   assign diff  = CMP_BITS'(hi) - CMP_BITS'(lo);
   assign twice = CMP_BITS'({padding_ff, 1'b0});

   always_comb begin
      token.vld    = req_valid && enable && op != REQ_NONE;
      token.op     = op;
      token.pos    = position_ff;
      token.start  = lo + pad;
      token.stop   = hi - pad;
      token.data   = data_byte;
      token.drop   = 1'b0;
      token.done   = 1'b0;
      token.status = ST_STORED;
      if (lo >= hi) begin
         token.done   = 1'b1;
         token.status = ST_ORDER;
      end else if (diff <= twice) begin
         token.done   = 1'b1;
         token.status = ST_SHORT;
      end
      position_in = position_ff;
      if (req_valid && enable) begin
         if (op == REQ_CLEAR) begin
            position_in = '0;
         end else if (op == REQ_DATA && position_ff != '1) begin
            position_in = position_ff + pos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         padding_ff  <= '0;
      end else begin
         position_ff <= position_in;
         if (csr_valid) begin
            padding_ff <= csr_data;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/brr_cell.sv
// ----------------------------------------------------------------------------
// brr_cell: one range cell
// Stores one range; checks the passing token against it, takes a load when
// free or passed, and hands the token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module brr_cell
   import brr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire token_type tok_in,
   output token_type      tok_out
);

   pos_type   start_ff, stop_ff;
   logic      valid_ff, valid_in;
   token_type tok_ff, tok_nxt;
   logic      take, live;

   assign live = valid_ff && tok_in.pos < stop_ff;

   always_comb begin
      tok_nxt  = tok_in;
      valid_in = valid_ff;
      take     = 1'b0;
      if (tok_in.vld) begin
         unique case (tok_in.op)
            REQ_LOAD: begin
               if (!tok_in.done && !live) begin
                  take         = 1'b1;
                  valid_in     = 1'b1;
                  tok_nxt.done = 1'b1;
               end
            end
            REQ_DATA: begin
               if (live && start_ff <= tok_in.pos) begin
                  tok_nxt.drop = 1'b1;
               end
            end
            REQ_CLEAR: valid_in = 1'b0;
            REQ_NONE:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && take) begin
         start_ff <= tok_in.start;
         stop_ff  <= tok_in.stop;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// File: rtl/brr_out.sv
// ----------------------------------------------------------------------------
// brr_out: result queue
// Turns the token leaving the last cell into a result and holds up to two
// results so the chain keeps moving while one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module brr_out
   import brr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type tok_in,
   input  wire logic      rsp_stall,
   output logic           enable,
   output logic           rsp_valid,
   output result_type     rsp
);

   logic [1:0] count_ff, count_in;
   result_type q0_ff, q1_ff, res;
   logic       push, pop, to_head;

   assign enable    = count_ff != 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp       = q0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign push      = enable && tok_in.vld &&
                      (tok_in.op == REQ_LOAD || (tok_in.op == REQ_DATA && !tok_in.drop));
   assign to_head   = push && (count_ff == 2'd0 || (count_ff == 2'd1 && pop));

   always_comb begin
      if (tok_in.op == REQ_LOAD) begin
         res.kind   = KIND_STATUS;
         res.data   = '0;
         res.status = tok_in.done ? tok_in.status : ST_FULL;
      end else begin
         res.kind   = KIND_DATA;
         res.data   = tok_in.data;
         res.status = ST_STORED;
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (to_head) begin
         q0_ff <= res;
      end else if (pop) begin
         q0_ff <= q1_ff;
      end
      if (push && !to_head) begin
         q1_ff <= res;
      end
   end

endmodule

`default_nettype wire

// File: rtl/byte_range_remover.sv
// ----------------------------------------------------------------------------
// byte_range_remover: drops stream bytes whose position lies in loaded ranges
// A head stage, a chain of range cells and a two-entry result queue.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  req      req_valid/stall    req_type, range_lo, range_hi, data_byte
//  rsp      rsp_valid/stall    out_kind, out_byte, load_status
//  csr      csr_valid/ready    csr_data (padding)
//
//  One transaction per cycle while req_stall is low; each token walks one
//  cell per cycle unless the chain holds, then enters the result queue.
//  Synchronous reset frees all cells and zeroes position and padding.
//  The whole chain holds when the result queue is full; req_stall follows.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_range_remover
   import brr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_type,
   input  wire logic [IN_BITS-1:0]  range_lo,
   input  wire logic [IN_BITS-1:0]  range_hi,
   input  wire logic [7:0]          data_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     out_kind,
   output logic [7:0]               out_byte,
   output logic [1:0]               load_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [PAD_BITS-1:0] csr_data
);

   token_type  chain [RANGE_CELLS+1];
   logic       enable;
   result_type rsp;

   assign req_stall = !enable;
   assign csr_ready = 1'b1;

   brr_head u_head (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .req_valid (req_valid),
      .req_type  (req_type),
      .range_lo  (range_lo),
      .range_hi  (range_hi),
      .data_byte (data_byte),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .token     (chain[0])
   );

   for (genvar i = 0; i < RANGE_CELLS; i++) begin : g_cell
      brr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   brr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .tok_in    (chain[RANGE_CELLS]),
      .rsp_stall (rsp_stall),
      .enable    (enable),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign out_kind    = rsp.kind;
   assign out_byte    = rsp.data;
   assign load_status = rsp.status;

endmodule

`default_nettype wire
